[rtl/rsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants for the postfix stack calculator: beat
// layouts, token codes, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int DATA_W    = 32;
	localparam int CNT_W     = 5;
	localparam int STATUS_W  = 3;
	// quotient bits produced by the divider after its overflow pre-check
	localparam int DIV_STEPS = DATA_W + 1;

	localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_OP    = 2'd1,
		MODE_START = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_UNDER = 3'd1,
		ST_DIVZ  = 3'd2,
		ST_OVER  = 3'd3,
		ST_IGN   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		RES_ADD  = 3'd0,
		RES_SUB  = 3'd1,
		RES_MUL  = 3'd2,
		RES_DIV  = 3'd3,
		RES_ZERO = 3'd4
	} res_sel_t;

	typedef struct packed {
		logic [1:0]               mode;
		logic signed [DATA_W-1:0] value;
		logic [1:0]               op_code;
	} tok_beat_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic [CNT_W-1:0]         stack_count;
		logic [STATUS_W-1:0]      status;
		logic                     saturated;
	} res_beat_t;

	// controller -> datapath
	typedef struct packed {
		logic     take;       // capture token
		logic     clear;      // start of expression
		logic     push;
		logic     set_abort;
		logic     rd;         // read second entry
		logic     mul_cap;    // register product
		logic     div_start;
		logic     wr_res;     // pop two, push result
		res_sel_t res_sel;
		logic     ld_status;
		status_t  status;
		logic     out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] op;
		logic       aborted;
		logic       full;
		logic       ge2;
		logic       top_zero;
		logic       div_done;
	} sts_t;

endpackage

[rtl/rsc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_div
// Fixed-point divider, one quotient bit per cycle: (num << FRAC_BITS) / den,
// truncated toward zero and clamped to 32 bits. den must be nonzero.
// ----------------------------------------------------------------------------
module rsc_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [rsc_pkg::DATA_W-1:0] num,
	input  logic signed [rsc_pkg::DATA_W-1:0] den,
	output logic                             done,
	output logic signed [rsc_pkg::DATA_W-1:0] quo,
	output logic                             sat
);

	localparam int W   = rsc_pkg::DATA_W;
	localparam int QW  = rsc_pkg::DIV_STEPS;
	localparam int CTW = $clog2(QW + 1);

	logic [W-1:0]     num_mag, den_mag;
	logic [2*W-1:0]   wide_n;
	logic [W-1:0]     rem_q, d_q;
	logic [QW-1:0]    low_q, q_q;
	logic             ovf_q, neg_q;
	logic             busy_q, done_q;
	logic [CTW-1:0]   cnt_q;
	logic [W:0]       trial;
	logic             ge;
	logic [W:0]       trial_sub;

	assign num_mag = num[W-1] ? (~num + 1'b1) : num;
	assign den_mag = den[W-1] ? (~den + 1'b1) : den;
	assign wide_n  = {{W{1'b0}}, num_mag} << FRAC_BITS;

	assign trial     = {rem_q, low_q[QW-1]};
	assign ge        = trial >= {1'b0, d_q};
	assign trial_sub = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CTW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// high part below the divisor unless the quotient exceeds QW bits
			rem_q <= {1'b0, wide_n[2*W-1:QW]};
			low_q <= wide_n[QW-1:0];
			d_q   <= den_mag;
			ovf_q <= {1'b0, wide_n[2*W-1:QW]} >= den_mag;
			neg_q <= num[W-1] ^ den[W-1];
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[W-1:0] : trial[W-1:0];
			low_q <= {low_q[QW-2:0], 1'b0};
			q_q   <= {q_q[QW-2:0], ge};
		end
	end

	always_comb begin
		if (neg_q) begin
			sat = ovf_q | q_q[QW-1] | (q_q[W-1] & (|q_q[W-2:0]));
			quo = sat ? rsc_pkg::DATA_MIN : (~q_q[W-1:0] + 1'b1);
		end else begin
			sat = ovf_q | q_q[QW-1] | q_q[W-1];
			quo = sat ? rsc_pkg::DATA_MAX : q_q[W-1:0];
		end
	end

	assign done = done_q;

endmodule

[rtl/rsc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_datapath
// Stack storage (top in a register, lower entries in memory), entry count,
// abort flag, arithmetic units and the result register.
// ----------------------------------------------------------------------------
module rsc_datapath #(
	parameter int STACK_DEPTH = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rsc_pkg::tok_beat_t tok,
	input  rsc_pkg::cmd_t      cmd,
	output rsc_pkg::sts_t      sts,
	output rsc_pkg::res_beat_t res
);

	localparam int W  = rsc_pkg::DATA_W;
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic signed [2*W-1:0] MAX_W = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [2*W-1:0] MIN_W = 64'shFFFF_FFFF_8000_0000;

	logic [W-1:0] mem [STACK_DEPTH];

	rsc_pkg::tok_beat_t tok_q;
	rsc_pkg::res_beat_t res_q;
	rsc_pkg::status_t   status_q;
	logic               sat_q;
	logic [CW-1:0]      count_q, cnt_m1, cnt_m2;
	logic [CW+rsc_pkg::CNT_W-1:0] cnt_ext;
	logic               aborted_q;
	logic signed [W-1:0]   top_q, rd_q;
	logic signed [2*W-1:0] prod_q, mul_sh;
	logic signed [W:0]     sum_w, diff_w;
	logic signed [W-1:0]   res_val, div_q;
	logic                  res_sat, div_sat, div_done;

	assign cnt_m1  = count_q - CW'(1);
	assign cnt_m2  = count_q - CW'(2);
	assign cnt_ext = {{rsc_pkg::CNT_W{1'b0}}, count_q};

	always_ff @(posedge clk) begin
		if (cmd.take) tok_q <= tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			aborted_q <= 1'b0;
		end else if (cmd.clear) begin
			count_q   <= '0;
			aborted_q <= 1'b0;
		end else begin
			if (cmd.push) count_q <= count_q + CW'(1);
			else if (cmd.wr_res) count_q <= cnt_m1;
			if (cmd.set_abort) aborted_q <= 1'b1;
		end
	end

	// memory holds entries below the top
	always_ff @(posedge clk) begin
		if (cmd.push && count_q != '0) mem[cnt_m1[AW-1:0]] <= top_q;
		if (cmd.rd) rd_q <= mem[cnt_m2[AW-1:0]];
	end

	assign sum_w  = {rd_q[W-1], rd_q} + {top_q[W-1], top_q};
	assign diff_w = {rd_q[W-1], rd_q} - {top_q[W-1], top_q};
	assign mul_sh = prod_q >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (cmd.mul_cap) prod_q <= rd_q * top_q;
	end

	rsc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (rd_q),
		.den   (top_q),
		.done  (div_done),
		.quo   (div_q),
		.sat   (div_sat)
	);

	always_comb begin
		res_val = '0;
		res_sat = 1'b0;
		case (cmd.res_sel)
			rsc_pkg::RES_ADD: begin
				res_sat = sum_w[W] ^ sum_w[W-1];
				res_val = res_sat ? (sum_w[W] ? rsc_pkg::DATA_MIN : rsc_pkg::DATA_MAX)
				                  : sum_w[W-1:0];
			end
			rsc_pkg::RES_SUB: begin
				res_sat = diff_w[W] ^ diff_w[W-1];
				res_val = res_sat ? (diff_w[W] ? rsc_pkg::DATA_MIN : rsc_pkg::DATA_MAX)
				                  : diff_w[W-1:0];
			end
			rsc_pkg::RES_MUL: begin
				if (mul_sh > MAX_W) begin
					res_sat = 1'b1;
					res_val = rsc_pkg::DATA_MAX;
				end else if (mul_sh < MIN_W) begin
					res_sat = 1'b1;
					res_val = rsc_pkg::DATA_MIN;
				end else begin
					res_val = mul_sh[W-1:0];
				end
			end
			rsc_pkg::RES_DIV: begin
				res_sat = div_sat;
				res_val = div_q;
			end
			rsc_pkg::RES_ZERO: res_val = '0;
			default: res_val = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.push) top_q <= tok_q.value;
		else if (cmd.wr_res) top_q <= res_val;
		if (cmd.ld_status) begin
			status_q <= cmd.status;
			sat_q    <= cmd.wr_res & res_sat;
		end
		if (cmd.out_load) begin
			res_q.top_value   <= (count_q != '0) ? top_q : '0;
			res_q.stack_count <= cnt_ext[rsc_pkg::CNT_W-1:0];
			res_q.status      <= status_q;
			res_q.saturated   <= sat_q;
		end
	end

	assign res = res_q;

	assign sts.mode     = tok_q.mode;
	assign sts.op       = tok_q.op_code;
	assign sts.aborted  = aborted_q;
	assign sts.full     = count_q == CW'(STACK_DEPTH);
	assign sts.ge2      = count_q >= CW'(2);
	assign sts.top_zero = top_q == '0;
	assign sts.div_done = div_done;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("entry count beyond stack depth");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> count_q != CW'(STACK_DEPTH))
		else $error("push into a full stack");

	a_pop_two: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_res || cmd.rd) |-> count_q >= CW'(2))
		else $error("operator executed with fewer than two entries");

	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !div_done)
		else $error("divider finished without iterating");

endmodule

[rtl/rsc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_ctrl
// Token sequencer: decodes the captured token, steps the datapath through
// operand read and arithmetic, and hands the result to the output register.
// ----------------------------------------------------------------------------
module rsc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          tok_valid,
	output logic          tok_stall,
	output logic          res_valid,
	input  logic          res_stall,
	input  rsc_pkg::sts_t sts,
	output rsc_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_READ   = 6'b000100,
		S_MUL    = 6'b001000,
		S_DIV    = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;

	assign tok_stall = state_q != S_IDLE;
	assign res_valid = res_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (tok_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.ld_status = 1'b1;
				cmd.status    = rsc_pkg::ST_OK;
				state_d       = S_OUT;
				case (sts.mode)
					rsc_pkg::MODE_START: cmd.clear = 1'b1;
					rsc_pkg::MODE_PUSH: begin
						if (sts.aborted) begin
							cmd.status = rsc_pkg::ST_IGN;
						end else if (sts.full) begin
							cmd.set_abort = 1'b1;
							cmd.status    = rsc_pkg::ST_OVER;
						end else begin
							cmd.push = 1'b1;
						end
					end
					rsc_pkg::MODE_OP: begin
						if (sts.aborted) begin
							cmd.status = rsc_pkg::ST_IGN;
						end else if (!sts.ge2) begin
							cmd.set_abort = 1'b1;
							cmd.status    = rsc_pkg::ST_UNDER;
						end else begin
							cmd.ld_status = 1'b0;
							cmd.rd        = 1'b1;
							state_d       = S_READ;
						end
					end
					default: begin
						if (sts.aborted) cmd.status = rsc_pkg::ST_IGN;
					end
				endcase
			end
			S_READ: begin
				cmd.status = rsc_pkg::ST_OK;
				case (sts.op)
					rsc_pkg::OP_ADD: begin
						cmd.wr_res    = 1'b1;
						cmd.res_sel   = rsc_pkg::RES_ADD;
						cmd.ld_status = 1'b1;
						state_d       = S_OUT;
					end
					rsc_pkg::OP_SUB: begin
						cmd.wr_res    = 1'b1;
						cmd.res_sel   = rsc_pkg::RES_SUB;
						cmd.ld_status = 1'b1;
						state_d       = S_OUT;
					end
					rsc_pkg::OP_MUL: begin
						cmd.mul_cap = 1'b1;
						state_d     = S_MUL;
					end
					default: begin
						if (sts.top_zero) begin
							cmd.wr_res    = 1'b1;
							cmd.res_sel   = rsc_pkg::RES_ZERO;
							cmd.ld_status = 1'b1;
							cmd.status    = rsc_pkg::ST_DIVZ;
							state_d       = S_OUT;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
					end
				endcase
			end
			S_MUL: begin
				cmd.wr_res    = 1'b1;
				cmd.res_sel   = rsc_pkg::RES_MUL;
				cmd.ld_status = 1'b1;
				cmd.status    = rsc_pkg::ST_OK;
				state_d       = S_OUT;
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.wr_res    = 1'b1;
					cmd.res_sel   = rsc_pkg::RES_DIV;
					cmd.ld_status = 1'b1;
					cmd.status    = rsc_pkg::ST_OK;
					state_d       = S_OUT;
				end
			end
			S_OUT: begin
				if (!res_valid_q || !res_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(res_valid_q && res_stall))
		else $error("result register overwritten while stalled");

	a_load_then_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> res_valid_q)
		else $error("loaded result not presented");

	a_take_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == S_DECODE)
		else $error("captured token not decoded");

endmodule

[rtl/rpn_stack_calculator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_core
// Postfix evaluator on a bounded stack of signed fixed-point values.
// ----------------------------------------------------------------------------
// Each token beat on tok pushes a number, applies an operator to the two top
// entries, or starts a new expression, and yields exactly one result beat on
// res with the new top, the entry count, a status code and a clamp flag.
// Tokens are taken one at a time: tok_stall is low only while the sequencer
// is idle. Start, push, ignored and aborting tokens go from decode straight to
// the output state; add and subtract pass through the operand read first,
// multiply through the read and the product register, and divide through the
// read and a wait on the divider, which produces one quotient bit per cycle
// over 33 steps. The next token can be taken the cycle after the result is
// loaded; the result register lets it proceed while that beat still waits on
// res_stall. Stack entries below the top live in a small memory with one
// registered read port; the top sits in a register. Underflow and overflow
// abort the expression until a start token; divide by zero leaves zero as
// the result and does not abort.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core #(
	parameter int STACK_DEPTH = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tok_valid,
	output logic               tok_stall,
	input  rsc_pkg::tok_beat_t tok,
	output logic               res_valid,
	input  logic               res_stall,
	output rsc_pkg::res_beat_t res
);

	// command and status between sequencer and datapath
	rsc_pkg::cmd_t cmd;
	rsc_pkg::sts_t sts;

	rsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsc_datapath #(
		.STACK_DEPTH(STACK_DEPTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.tok   (tok),
		.cmd   (cmd),
		.sts   (sts),
		.res   (res)
	);

endmodule
